### design/q2r_pkg.sv
`timescale 1ns / 1ps
package q2r_pkg;
  localparam int unsigned InW  = 16;
  localparam int unsigned NumW = 35;
  localparam int unsigned NW   = 34;
  localparam int unsigned NEnt = 9;
  localparam logic signed [InW-1:0] SatMax = 16'sh7fff;
  localparam logic signed [InW-1:0] SatMin = 16'sh8000;
  typedef logic signed [NumW-1:0] num_t;
endpackage

### design/q2r_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: q = round(mag * 2^FRAC_BITS / n), one quotient bit per stage.
module q2r_div #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [q2r_pkg::NW-1:0]        mag_i,
  input  logic [q2r_pkg::NW-1:0]        n_i,
  input  logic                          neg_i,
  output logic signed [q2r_pkg::InW-1:0] res_o
);
  localparam int unsigned QB = FRAC_BITS + 2;
  localparam int unsigned RW = q2r_pkg::NW + 1;
  localparam int unsigned CW = QB + 17;
  logic [RW-1:0]             rem_q [QB+1];
  logic [q2r_pkg::NW-1:0]    den_q [QB+1];
  logic [QB-1:0]             quo_q [QB+1];
  logic                      neg_q [QB+1];
  logic [RW-1:0]             den_ext [QB];
  logic [RW-1:0]             sh_rem [QB];
  logic [CW-1:0]             qr;
  logic [CW-1:0]             qs;

  always_comb begin
    rem_q[0] = {1'b0, mag_i};
    den_q[0] = n_i;
    quo_q[0] = '0;
    neg_q[0] = neg_i;
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    assign den_ext[s] = {1'b0, den_q[s]};
    assign sh_rem[s] = (s == 0) ? rem_q[s] : {rem_q[s][RW-2:0], 1'b0};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        if (sh_rem[s] >= den_ext[s]) begin
          rem_q[s+1] <= sh_rem[s] - den_ext[s];
          quo_q[s+1] <= {quo_q[s][QB-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= sh_rem[s];
          quo_q[s+1] <= {quo_q[s][QB-2:0], 1'b0};
        end
      end
    end
  end

  // quotient holds floor(2*mag*2^F/n); round half away is (q+1)>>1
  always_comb begin
    qr = (CW'(quo_q[QB]) + CW'(1)) >> 1;
    qs = -qr;
    if (neg_q[QB]) begin
      res_o = (qr > CW'(32768)) ? q2r_pkg::SatMin : q2r_pkg::InW'(qs);
    end else begin
      res_o = (qr > CW'(32767)) ? q2r_pkg::SatMax : q2r_pkg::InW'(qr);
    end
  end
endmodule

### design/quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake       Payload
// command   in         start_i/busy_o  quat_w_i quat_x_i quat_y_i quat_z_i
// result    out        done_o strobe   r00_o .. r22_o, zero_norm_o
//
// One quaternion per cycle; busy_o is always low. The pipeline has
// two multiply/add stages, FRAC_BITS+2 divider stages (one quotient bit each), output register.
// Reset clears only the valid bits; payload registers run free.
// The receiver cannot stall, so the pipe never holds.
module quaternion_to_rotation_matrix #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [15:0]          quat_w_i,
  input  logic signed [15:0]          quat_x_i,
  input  logic signed [15:0]          quat_y_i,
  input  logic signed [15:0]          quat_z_i,
  output logic                        done_o,
  output logic signed [15:0]          r00_o,
  output logic signed [15:0]          r01_o,
  output logic signed [15:0]          r02_o,
  output logic signed [15:0]          r10_o,
  output logic signed [15:0]          r11_o,
  output logic signed [15:0]          r12_o,
  output logic signed [15:0]          r20_o,
  output logic signed [15:0]          r21_o,
  output logic signed [15:0]          r22_o,
  output logic                        zero_norm_o
);
  localparam int unsigned Lat = FRAC_BITS + 2;
  localparam int unsigned NumW = q2r_pkg::NumW;
  localparam int unsigned NW = q2r_pkg::NW;

  // stage 1: products
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic               v1_q;
  // stage 2: numerators and norm
  q2r_pkg::num_t      num_q [q2r_pkg::NEnt];
  logic [NW-1:0]      n_q;
  logic               v2_q;
  // divider side band
  logic [Lat-1:0]     vd_q;
  logic [Lat-1:0]     zd_q;
  logic [NW-1:0]      n_div;
  logic signed [15:0] res [q2r_pkg::NEnt];
  logic signed [15:0] out_q [q2r_pkg::NEnt];
  logic               done_q, zero_q;
  logic signed [15:0] one16;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i) begin
    ww_q <= quat_w_i * quat_w_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
    wz_q <= quat_w_i * quat_z_i;
    xz_q <= quat_x_i * quat_z_i;
    wy_q <= quat_w_i * quat_y_i;
    yz_q <= quat_y_i * quat_z_i;
    wx_q <= quat_w_i * quat_x_i;
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= NumW'(ww_q) + NumW'(xx_q) - NumW'(yy_q) - NumW'(zz_q);
    num_q[1] <= (NumW'(xy_q) - NumW'(wz_q)) <<< 1;
    num_q[2] <= (NumW'(xz_q) + NumW'(wy_q)) <<< 1;
    num_q[3] <= (NumW'(xy_q) + NumW'(wz_q)) <<< 1;
    num_q[4] <= NumW'(ww_q) - NumW'(xx_q) + NumW'(yy_q) - NumW'(zz_q);
    num_q[5] <= (NumW'(yz_q) - NumW'(wx_q)) <<< 1;
    num_q[6] <= (NumW'(xz_q) - NumW'(wy_q)) <<< 1;
    num_q[7] <= (NumW'(yz_q) + NumW'(wx_q)) <<< 1;
    num_q[8] <= NumW'(ww_q) - NumW'(xx_q) - NumW'(yy_q) + NumW'(zz_q);
    n_q <= NW'($unsigned(ww_q)) + NW'($unsigned(xx_q)) + NW'($unsigned(yy_q))
         + NW'($unsigned(zz_q));
  end

  // a zero norm divides by one; the result is replaced at the output anyway
  assign n_div = (n_q == '0) ? NW'(1) : n_q;

  for (genvar k = 0; k < q2r_pkg::NEnt; k++) begin : g_ent
    logic [NumW-1:0] mag_full;
    logic [NW-1:0]   mag;
    assign mag_full = num_q[k][NumW-1] ? NumW'(-num_q[k]) : NumW'(num_q[k]);
    // clamp to the norm
    assign mag = (mag_full[NW-1:0] > n_div) ? n_div : mag_full[NW-1:0];
    q2r_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (1'b1),
      .mag_i (mag),
      .n_i   (n_div),
      .neg_i (num_q[k][NumW-1]),
      .res_o (res[k])
    );
  end

  // advance valid and zero flags alongside the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vd_q <= '0;
      done_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      vd_q <= {vd_q[Lat-2:0], v2_q};
      done_q <= vd_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    zd_q <= {zd_q[Lat-2:0], (n_q == '0)};
  end

  assign one16 = (FRAC_BITS >= 15) ? q2r_pkg::SatMax : 16'(1 << FRAC_BITS);

  always_ff @(posedge clk_i) begin
    zero_q <= zd_q[Lat-1];
    for (int k = 0; k < q2r_pkg::NEnt; k++) begin
      if (zd_q[Lat-1]) begin
        out_q[k] <= (k == 0 || k == 4 || k == 8) ? one16 : '0;
      end else begin
        out_q[k] <= res[k];
      end
    end
  end

  assign done_o = done_q;
  assign zero_norm_o = zero_q;
  assign r00_o = out_q[0];
  assign r01_o = out_q[1];
  assign r02_o = out_q[2];
  assign r10_o = out_q[3];
  assign r11_o = out_q[4];
  assign r12_o = out_q[5];
  assign r20_o = out_q[6];
  assign r21_o = out_q[7];
  assign r22_o = out_q[8];
endmodule

### design/q2r_checker.sv
`timescale 1ns / 1ps
module q2r_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic               zero_norm_o,
  input logic signed [15:0] r00_o,
  input logic signed [15:0] r01_o,
  input logic signed [15:0] r11_o,
  input logic signed [15:0] r22_o
);
  a_nobusy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_idzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_norm_o) |-> (r01_o == 16'sd0 && r00_o == r11_o && r11_o == r22_o))
    else $error("zero quaternion not identity");
  a_nodone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start_i ##1 !start_i ##1 !start_i) |-> ##17 !done_o)
    else $error("result without transfer");
endmodule

bind quaternion_to_rotation_matrix q2r_checker u_q2r_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .zero_norm_o(zero_norm_o), .r00_o(r00_o), .r01_o(r01_o),
  .r11_o(r11_o), .r22_o(r22_o)
);

### bench/quaternion_to_rotation_matrix_tb.sv
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_tb;

  localparam int unsigned FracBits = 14;
  localparam int unsigned Latency = FracBits + 5;
  localparam int unsigned NumRandom = 500;
  localparam longint CycleLimit = 200000;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic [8:0][15:0] ent;
    logic zero_norm;
  } matrix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic busy_o, done_o, zero_norm_o;
  logic signed [15:0] r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  quat_t   pending_quats[$];
  matrix_t expected_matrices[$];
  int      error_count = 0;
  bit      stimulus_done = 1'b0;
  bit      calm_phase = 1'b0;
  int      gap_left = 0;
  longint  cycle_count = 0;

  quaternion_to_rotation_matrix #(.FRAC_BITS(FracBits)) dut (.*);

  always #6 clk_i = ~clk_i;

  // Clamp |num| to n, round num * 2^FracBits / n to nearest, ties away from zero, then saturate.
  function automatic logic signed [15:0] rounded_entry(longint num, longint n);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    if (mag > n) mag = n;
    q = ((mag <<< (FracBits + 1)) + n) / (2 * n);
    if (num < 0) begin
      q = -q;
    end
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic matrix_t rotation_of(quat_t q);
    longint w, x, y, z, ww, xx, yy, zz, n, one;
    longint num[9];
    matrix_t m;
    w = q.w; x = q.x; y = q.y; z = q.z;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    n = ww + xx + yy + zz;
    m = '0;
    if (n == 0) begin
      // All-zero input: identity with the flag raised.
      one = longint'(1) << FracBits;
      if (one > 32767) one = 32767;
      m.ent[0] = one[15:0];
      m.ent[4] = one[15:0];
      m.ent[8] = one[15:0];
      m.zero_norm = 1'b1;
      return m;
    end
    num[0] = ww + xx - yy - zz;
    num[1] = 2 * (x * y - w * z);
    num[2] = 2 * (x * z + w * y);
    num[3] = 2 * (x * y + w * z);
    num[4] = ww - xx + yy - zz;
    num[5] = 2 * (y * z - w * x);
    num[6] = 2 * (x * z - w * y);
    num[7] = 2 * (y * z + w * x);
    num[8] = ww - xx - yy + zz;
    for (int k = 0; k < 9; k++) m.ent[k] = rounded_entry(num[k], n);
    return m;
  endfunction

  function automatic logic signed [15:0] random_part();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  // Driver: pop one quaternion per transfer, with random bursts of idle cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_matrices.push_back(rotation_of({quat_w_i, quat_x_i, quat_y_i, quat_z_i}));
      end
      if (start_i && busy_o) begin
        // hold the current item until the block takes it
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 2);
        start_i <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        quat_t q;
        q = pending_quats.pop_front();
        {quat_w_i, quat_x_i, quat_y_i, quat_z_i} <= q;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // Monitor: compare each strobed matrix with the oldest expectation.
  always @(posedge clk_i) begin
    matrix_t got, exp_m;
    got.ent = {r22_o, r21_o, r20_o, r12_o, r11_o, r10_o, r02_o, r01_o, r00_o};
    got.zero_norm = zero_norm_o;
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      if (expected_matrices.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        error_count = error_count + 1;
      end else begin
        exp_m = expected_matrices.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got.ent[k] !== exp_m.ent[k]) begin
            $display("%0t: entry r%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                     $signed(exp_m.ent[k]), $signed(got.ent[k]));
            error_count = error_count + 1;
          end
        end
        if (got.zero_norm !== exp_m.zero_norm) begin
          $display("%0t: zero_norm expected %b actual %b", $time, exp_m.zero_norm,
                   got.zero_norm);
          error_count = error_count + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    quat_t q;
    // Directed: zero quaternion, axis-aligned units, extremes, tiny magnitudes.
    pending_quats.push_back('0);
    pending_quats.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    pending_quats.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_quats.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_quats.push_back({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    pending_quats.push_back({16'sh8000, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sh8000});
    pending_quats.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd0, -16'sd1, 16'sd0, 16'sd0});
    pending_quats.push_back({16'sd1, 16'sd1, 16'sd1, 16'sd1});
    pending_quats.push_back({16'sd1, 16'sd2, 16'sd3, 16'sd0});
    pending_quats.push_back({16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
    pending_quats.push_back('0);
    for (int i = 0; i < NumRandom; i++) begin
      q.w = random_part();
      q.x = random_part();
      q.y = random_part();
      q.z = random_part();
      pending_quats.push_back(q);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Drop idling for the last part of the run.
    wait (pending_quats.size() < 60);
    calm_phase = 1'b1;
    wait (stimulus_done && expected_matrices.size() == 0);
    repeat (Latency + 5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### quaternion_to_rotation_matrix.f
design/q2r_pkg.sv
design/q2r_div.sv
design/quaternion_to_rotation_matrix.sv
design/q2r_checker.sv
bench/quaternion_to_rotation_matrix_tb.sv
